[src/mvcc_read_view_visibility_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the read-view visibility block
// Wrap concurrent checks so that synthesis sees no assertion text.
// ---------------------------------------------------------------------------
`ifndef MVCC_READ_VIEW_VISIBILITY_ASSERT_SVH
`define MVCC_READ_VIEW_VISIBILITY_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define MVCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mvcc assertion failed");

// Check that a condition never occurs outside reset.
`define MVCC_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mvcc forbidden condition seen");

`else

`define MVCC_ASSERT(label, clk, rst_n, prop)
`define MVCC_NEVER(label, clk, rst_n, cond)

`endif

`endif

[src/mvcc_pkg.sv]
// ---------------------------------------------------------------------------
// mvcc_pkg
// Types and constants shared by the read-view visibility block.
// ---------------------------------------------------------------------------
package mvcc_pkg;

    localparam int ID_W = 27;
    localparam int NU_W = ID_W + 1;

    // Lowest-active value when no stored id is lower.
    localparam logic [ID_W-1:0] NO_ACTIVE = 27'd100000001;

    // Operation codes
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHECK  = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] txn_id;
    } item_t;

    typedef struct packed {
        logic       visible;
        logic [1:0] status;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } mvcc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
    } mvcc_stat_t;

endpackage

[src/mvcc_dpath.sv]
// ---------------------------------------------------------------------------
// mvcc_dpath
// Id table, limits, slot scan and result register.
// ---------------------------------------------------------------------------
module mvcc_dpath
    import mvcc_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mvcc_cmd_t  cmd,
    output mvcc_stat_t stat,
    input  item_t      item,
    output result_t    result
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [ID_W-1:0]  id_mem [SLOTS];
    logic [SLOTS-1:0] slot_vld_reg;

    item_t            item_reg;
    logic [IDX_W-1:0] scan_idx_reg;

    logic [ID_W-1:0]  rd_id_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_go_reg;

    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [ID_W-1:0]  min_reg;

    logic [ID_W-1:0]  lowest_reg;
    logic [NU_W-1:0]  nu_reg;        // zero stands for "nothing added yet"
    result_t          result_reg;

    logic             is_match;
    logic             take_hit;
    logic [NU_W-1:0]  id_ext;
    logic [NU_W-1:0]  id_inc;
    result_t          result_next;
    logic [ID_W-1:0]  lowest_next;
    logic [NU_W-1:0]  nu_next;

    assign stat.scan_last = (scan_idx_reg == LAST_IDX);
    assign result         = result_reg;

    // A hit is a free slot for add, a valid equal id otherwise.
    always_comb
    begin
        if (item_reg.kind == KIND_ADD)
        begin
            is_match = !rd_vld_reg;
        end
        else
        begin
            is_match = rd_vld_reg && (rd_id_reg == item_reg.txn_id);
        end
        take_hit = rd_go_reg && is_match && !found_reg;
    end

    assign id_ext = {1'b0, item_reg.txn_id};
    assign id_inc = id_ext + NU_W'(1);

    always_comb
    begin
        result_next = '0;
        lowest_next = lowest_reg;
        nu_next     = nu_reg;
        case (item_reg.kind)
            KIND_ADD:
            begin
                if (found_reg)
                begin
                    result_next.status = STATUS_OK;
                    if (id_inc > nu_reg)
                    begin
                        nu_next = id_inc;
                    end
                    if (item_reg.txn_id < lowest_reg)
                    begin
                        lowest_next = item_reg.txn_id;
                    end
                end
                else
                begin
                    result_next.status = STATUS_FULL;
                end
            end
            KIND_REMOVE:
            begin
                if (found_reg)
                begin
                    result_next.status = STATUS_OK;
                    lowest_next        = min_reg;
                end
                else
                begin
                    result_next.status = STATUS_NOT_FOUND;
                end
            end
            KIND_CHECK:
            begin
                if (item_reg.txn_id < lowest_reg)
                begin
                    result_next.visible = 1'b1;
                end
                else if (id_ext >= nu_reg)
                begin
                    result_next.visible = 1'b0;
                end
                else
                begin
                    result_next.visible = !found_reg;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // Control state of the scan and the limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
            rd_go_reg    <= 1'b0;
            lowest_reg   <= NO_ACTIVE;
            nu_reg       <= '0;
        end
        else
        begin
            rd_go_reg <= cmd.scan;
            if (cmd.commit)
            begin
                lowest_reg <= lowest_next;
                nu_reg     <= nu_next;
                if (found_reg && (item_reg.kind == KIND_ADD))
                begin
                    slot_vld_reg[hit_idx_reg] <= 1'b1;
                end
                if (found_reg && (item_reg.kind == KIND_REMOVE))
                begin
                    slot_vld_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg     <= item;
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            min_reg      <= NO_ACTIVE;
        end
        else
        begin
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (take_hit)
            begin
                found_reg   <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
            end
            // Leave the removed copy out of the new minimum.
            if (rd_go_reg && rd_vld_reg && !take_hit && (rd_id_reg < min_reg))
            begin
                min_reg <= rd_id_reg;
            end
        end
        if (cmd.scan)
        begin
            rd_vld_reg <= slot_vld_reg[scan_idx_reg];
            rd_idx_reg <= scan_idx_reg;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    // Id table: one read port for the scan, one write port for add
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_id_reg <= id_mem[scan_idx_reg];
        end
        if (cmd.commit && found_reg && (item_reg.kind == KIND_ADD))
        begin
            id_mem[hit_idx_reg] <= item_reg.txn_id;
        end
    end

endmodule

[src/mvcc_ctrl.sv]
// ---------------------------------------------------------------------------
// mvcc_ctrl
// Sequencer for accept, table scan, commit and result hand-off.
// ---------------------------------------------------------------------------
`include "mvcc_read_view_visibility_assert.svh"

module mvcc_ctrl
    import mvcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output mvcc_cmd_t  cmd,
    input  mvcc_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_busy;

    assign out_busy   = out_valid_reg && out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;

    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_FINISH) && !out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop valid after the transfer unless a new result replaces it.
            if (out_valid_reg && !out_stall && !cmd.commit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (stat.scan_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_busy)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MVCC_ASSERT(a_commit_shows_result, clk, rst_n, cmd.commit |=> out_valid_reg)
    `MVCC_NEVER(a_no_overwrite, clk, rst_n, cmd.commit && out_valid_reg && out_stall)
    `MVCC_ASSERT(a_drain_then_finish, clk, rst_n, (state_reg == S_DRAIN) |=> (state_reg == S_FINISH))
    `MVCC_ASSERT(a_load_starts_scan, clk, rst_n, cmd.load |=> (state_reg == S_SCAN))

endmodule

[src/mvcc_read_view_visibility.sv]
// Read-view visibility block: keeps a table of SLOTS active transaction ids with
// the lowest active id and one past the highest id ever added, and answers one
// result per item (add, remove or visibility check). Every item holds the input
// through an accept step, a scan of every table slot on the single read port
// of the id table, a drain step for the last read to land, and a commit step,
// which loads the result register. A finished result sits in the output
// register, so the next item transfers while the result still waits; commit
// holds only while an earlier result is stalled.
// No clearing pass runs after reset: slot valid bits reset in flip-flops.
// ---------------------------------------------------------------------------
// mvcc_read_view_visibility
// Top level: sequencer plus datapath for the MVCC read-view check.
// ---------------------------------------------------------------------------
module mvcc_read_view_visibility
    import mvcc_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    mvcc_cmd_t  cmd;
    mvcc_stat_t stat;

    // Sequence each transfer: accept, scan every slot, drain, commit.
    mvcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_stall  (item_stall),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Hold the id table, both limits and the result register.
    mvcc_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule

[test/tb_mvcc_read_view_visibility.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mvcc_read_view_visibility
// Self-checking bench for the read-view visibility block. A driver streams
// add, remove and check items over the valid/stall input channel. A shadow
// of the active-id table and its two limits predicts one result per accepted
// transfer. A monitor compares every result transfer with the oldest
// prediction. The run opens with a directed sequence and follows it with
// three random phases that differ in how often each side idles.
// ---------------------------------------------------------------------------
module tb_mvcc_read_view_visibility;
    import mvcc_pkg::*;

    localparam int TABLE_SLOTS = 16;
    // Kind code that the block leaves unused: no state change, zero result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [ID_W-1:0] ID_MAX = '1;
    localparam int ID_TOP = 100000000;
    // Wait well beyond the time a result takes to come back.
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 12;

    typedef struct {
        item_t   cause;
        result_t want;
    } answer_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Shadow of the view: stored ids, their valid bits, the lowest active id
    // and one past the highest id ever added (minus one until the first add).
    logic [ID_W-1:0] view_ids [TABLE_SLOTS];
    logic            view_used [TABLE_SLOTS];
    int              view_low;
    int              view_high;

    item_t           pending_items [$];
    answer_t         expected_answers [$];
    logic [ID_W-1:0] recent_ids [$];

    int sender_idle_pct = 31;
    int receiver_idle_pct = 51;
    int mismatches = 0;

    mvcc_read_view_visibility #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Apply one item to the shadow view and return the result it must give.
    function automatic result_t apply_to_view(item_t it);
        result_t r;
        int      id;
        int      slot;
        int      i;
        r = '0;
        id = int'(it.txn_id);
        slot = -1;
        case (it.kind)
            KIND_ADD:
            begin
                for (i = 0; i < TABLE_SLOTS; i++)
                    if (!view_used[i] && slot < 0)
                        slot = i;
                if (slot < 0)
                    r.status = STATUS_FULL;
                else
                begin
                    view_ids[slot] = it.txn_id;
                    view_used[slot] = 1'b1;
                    if (id + 1 > view_high)
                        view_high = id + 1;
                    if (id < view_low)
                        view_low = id;
                end
            end
            KIND_REMOVE:
            begin
                for (i = 0; i < TABLE_SLOTS; i++)
                    if (view_used[i] && view_ids[i] == it.txn_id && slot < 0)
                        slot = i;
                if (slot < 0)
                    r.status = STATUS_NOT_FOUND;
                else
                begin
                    // Clear one copy only, then rebuild the lowest active id.
                    view_used[slot] = 1'b0;
                    view_low = int'(NO_ACTIVE);
                    for (i = 0; i < TABLE_SLOTS; i++)
                        if (view_used[i] && int'(view_ids[i]) < view_low)
                            view_low = int'(view_ids[i]);
                end
            end
            KIND_CHECK:
            begin
                if (id < view_low)
                    r.visible = 1'b1;
                else if (id >= view_high)
                    r.visible = 1'b0;
                else
                begin
                    r.visible = 1'b1;
                    for (i = 0; i < TABLE_SLOTS; i++)
                        if (view_used[i] && view_ids[i] == it.txn_id)
                            r.visible = 1'b0;
                end
            end
            default:
            begin
                // Unused kind: leave the view alone and answer zero.
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver: predict on every input transfer, then advance to the next
    // pending item or drop valid. Hold the payload while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_answers.push_back('{item, apply_to_view(item)});
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item <= pending_items.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random at the current idle rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Monitor: match every result transfer against the oldest prediction.
    always @(posedge clk)
    begin : take_result
        answer_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_answers.size() == 0)
                report_mismatch($sformatf("result %0b/%0d with no item outstanding",
                                          result.visible, result.status));
            else
            begin
                due = expected_answers.pop_front();
                if (result.visible !== due.want.visible)
                    report_mismatch($sformatf("kind %0d id %0d: visible %0b, want %0b",
                                              due.cause.kind, due.cause.txn_id,
                                              result.visible, due.want.visible));
                if (result.status !== due.want.status)
                    report_mismatch($sformatf("kind %0d id %0d: status %0d, want %0d",
                                              due.cause.kind, due.cause.txn_id,
                                              result.status, due.want.status));
            end
        end
    end

    task automatic push_item(logic [1:0] kind, logic [ID_W-1:0] id);
        item_t it;
        it.kind = kind;
        it.txn_id = id;
        pending_items.push_back(it);
    endtask

    // Hold the test sequence until every item has transferred and every
    // predicted result has come back.
    task automatic drain_all();
        while (pending_items.size() != 0 || item_valid || expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // Bias ids toward recently added ones so removes and checks hit the table.
    function automatic logic [ID_W-1:0] pick_id();
        int sel;
        int k;
        sel = $urandom_range(99);
        k = (recent_ids.size() != 0) ? $urandom_range(recent_ids.size() - 1) : 0;
        if (sel < 45 && recent_ids.size() != 0)
            return recent_ids[k];
        if (sel < 60 && recent_ids.size() != 0)
            return $urandom_range(1) ? recent_ids[k] + 1'b1 : recent_ids[k] - 1'b1;
        if (sel < 80)
            return ID_W'($urandom_range(ID_TOP, 0));
        if (sel < 88)
            return ID_W'($urandom_range(63, 0));
        if (sel < 94)
            return ID_W'($urandom_range(ID_MAX, NO_ACTIVE));
        return ID_W'($urandom() & ID_MAX);
    endfunction

    // Queue random traffic in bursts whose add weight swings from filling
    // the table to draining it.
    task automatic queue_random_items(int count);
        int add_weight;
        int sel;
        logic [ID_W-1:0] id;
        add_weight = 80;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                add_weight = (n % 160 == 0) ? 80 : (n % 160 == 80) ? 20 : 50;
            sel = $urandom_range(99);
            id = pick_id();
            if (sel < add_weight)
            begin
                push_item(KIND_ADD, id);
                recent_ids.push_back(id);
                if (recent_ids.size() > 24)
                    void'(recent_ids.pop_front());
            end
            else if (sel < add_weight + (95 - add_weight) / 2)
                push_item(KIND_REMOVE, id);
            else if (sel < 95)
                push_item(KIND_CHECK, id);
            else
                push_item(KIND_UNUSED, id);
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            view_ids[i] = '0;
            view_used[i] = 1'b0;
        end
        view_low = int'(NO_ACTIVE);
        view_high = -1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty view, limits on both sides, duplicates, misses,
        // ids beyond the nominal range and the unused kind.
        push_item(KIND_CHECK, 27'd12345);
        push_item(KIND_REMOVE, 27'd7);
        push_item(KIND_UNUSED, ID_MAX);
        push_item(KIND_ADD, 27'd1000);
        push_item(KIND_CHECK, 27'd999);
        push_item(KIND_CHECK, 27'd1001);
        push_item(KIND_CHECK, 27'd1000);
        push_item(KIND_ADD, 27'd1000);
        push_item(KIND_ADD, 27'd0);
        push_item(KIND_ADD, ID_MAX);
        push_item(KIND_CHECK, 27'd500);
        push_item(KIND_CHECK, 27'd0);
        push_item(KIND_CHECK, ID_MAX);
        push_item(KIND_REMOVE, 27'd1000);
        push_item(KIND_CHECK, 27'd1000);
        push_item(KIND_REMOVE, 27'd1000);
        push_item(KIND_CHECK, 27'd1000);
        push_item(KIND_REMOVE, 27'd1000);
        push_item(KIND_REMOVE, 27'd0);
        push_item(KIND_CHECK, 27'd0);
        push_item(KIND_ADD, 27'd100000000);
        push_item(KIND_REMOVE, ID_MAX);
        push_item(KIND_CHECK, 27'd100000000);
        push_item(KIND_REMOVE, 27'd100000000);
        push_item(KIND_CHECK, ID_MAX - 1'b1);
        // Pause the sender until the view is quiet.
        drain_all();

        queue_random_items(340);
        drain_all();

        sender_idle_pct = 51;
        receiver_idle_pct = 31;
        queue_random_items(330);
        drain_all();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        queue_random_items(330);
        drain_all();

        // Let any stray result surface before judging the run.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("mvcc_read_view_visibility regression: pass");
        else
            $display("mvcc_read_view_visibility regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("mvcc_read_view_visibility regression: fail");
        $finish;
    end

endmodule
